/* src/text_console_cursor_engine_macros.svh */
// assertion macros used by the cursor engine back end
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define TCCE_CHECK(LBL, CLK, RSTN, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (PROP)) \
    else $error(MSG);

// consequent checked at the edge after the antecedent
`define TCCE_CHECK_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`else

`define TCCE_CHECK(LBL, CLK, RSTN, PROP, MSG)
`define TCCE_CHECK_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG)

`endif

`endif

/* src/tcce_pkg.sv */
// types, constants and codes of the text console cursor engine
package tcce_pkg;

  localparam int COLUMNS_DEF     = 40;
  localparam int ROWS_DEF        = 25;
  localparam int TAB_STOP_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CODE_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 5;
  localparam int KIND_W     = 2;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CODE_W-1:0] CODE_TAB    = 8'h09;
  localparam logic [CODE_W-1:0] CODE_LF     = 8'h0a;
  localparam logic [CODE_W-1:0] CODE_CR     = 8'h0d;
  localparam logic [CODE_W-1:0] GLYPH_SPACE = 8'h20;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'd1;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'd7;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 8'd0;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_TAB  = 2'd1,
    OP_LF   = 2'd2,
    OP_CR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] glyph;
    logic              adv;
    logic              inv;
  } cmd_t;

endpackage

/* src/tcce_channels.sv */
// valid/ready channel interfaces for characters in and results out
interface tcce_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcce_pkg::CODE_W-1:0]  char_code;
  logic                         advance;
  logic                         inverse;

  modport source (output valid, output char_code, output advance, output inverse,
                  input ready);
  modport sink   (input valid, input char_code, input advance, input inverse,
                  output ready);
endinterface

interface tcce_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcce_pkg::KIND_W-1:0]  kind;
  logic [tcce_pkg::COL_W-1:0]   cell_column;
  logic [tcce_pkg::ROW_W-1:0]   cell_row;
  logic [tcce_pkg::CODE_W-1:0]  glyph;
  logic [tcce_pkg::COLOR_W-1:0] fore_color;
  logic [tcce_pkg::COLOR_W-1:0] back_fill;
  logic                         last;

  modport source (output valid, output kind, output cell_column, output cell_row,
                  output glyph, output fore_color, output back_fill, output last,
                  input ready);
  modport sink   (input valid, input kind, input cell_column, input cell_row,
                  input glyph, input fore_color, input back_fill, input last,
                  output ready);
endinterface

/* src/tcce_front.sv */
// front end: takes character words and classifies them into commands
module tcce_front (
  tcce_in_if.sink          in_chan,
  output logic             push_valid,
  input  logic             push_ready,
  output tcce_pkg::cmd_t   push_data
);

  tcce_pkg::op_t op;

  always_comb begin
    unique case (in_chan.char_code)
      tcce_pkg::CODE_TAB: op = tcce_pkg::OP_TAB;
      tcce_pkg::CODE_LF:  op = tcce_pkg::OP_LF;
      tcce_pkg::CODE_CR:  op = tcce_pkg::OP_CR;
      default:            op = tcce_pkg::OP_CHAR;
    endcase
  end

  assign push_valid      = in_chan.valid;
  assign in_chan.ready   = push_ready;
  assign push_data.op    = op;
  assign push_data.glyph = in_chan.char_code;
  assign push_data.adv   = in_chan.advance;
  assign push_data.inv   = in_chan.inverse;

endmodule

/* src/tcce_fifo.sv */
// short command queue between front and back end
module tcce_fifo #(
  parameter int DEPTH = tcce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcce_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tcce_pkg::cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcce_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/tcce_back.sv */
// back end: cursor state, color registers and result sequencing
`include "text_console_cursor_engine_macros.svh"

module tcce_back #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  tcce_pkg::cmd_t                    pop_data,
  tcce_out_if.source                        out_chan
);

  localparam int COL_W   = tcce_pkg::COL_W;
  localparam int ROW_W   = tcce_pkg::ROW_W;
  localparam int PHASE_W = tcce_pkg::PHASE_W;
  localparam int COLOR_W = tcce_pkg::COLOR_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WRITE  = 4'b0010,
    S_SCROLL = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  tcce_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [PHASE_W-1:0]          phase_r, phase_nxt;
  logic [COLOR_W-1:0]          text_color_r, back_color_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [tcce_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [COL_W-1:0]            out_col_r, out_col_nxt;
  logic [ROW_W-1:0]            out_row_r, out_row_nxt;
  logic [COLOR_W-1:0]          out_glyph_r, out_glyph_nxt;
  logic [COLOR_W-1:0]          out_fore_r, out_fore_nxt;
  logic [COLOR_W-1:0]          out_back_r, out_back_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        emit_ok, emit;
  logic [COL_W-1:0]            col_inc;
  logic [PHASE_W:0]            phase_inc;
  logic                        row_at_bottom;
  logic [COLOR_W-1:0]          fore_sel, back_sel;

  assign emit_ok       = !out_valid_r || out_chan.ready;
  assign pop_ready     = (state_r == S_IDLE);
  assign col_inc       = col_r + COL_W'(1);
  assign phase_inc     = {1'b0, phase_r} + (PHASE_W + 1)'(1);
  assign row_at_bottom = (row_r >= ROW_W'(ROWS - 1));
  assign fore_sel      = cmd_r.inv ? back_color_r : text_color_r;
  assign back_sel      = cmd_r.inv ? text_color_r : back_color_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    phase_nxt     = phase_r;
    emit          = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_glyph_nxt = out_glyph_r;
    out_fore_nxt  = out_fore_r;
    out_back_nxt  = out_back_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          cmd_nxt = pop_data;
          unique case (pop_data.op)
            tcce_pkg::OP_LF: begin
              col_nxt   = '0;
              phase_nxt = '0;
              if (row_at_bottom) begin
                state_nxt = S_SCROLL;
              end else begin
                row_nxt   = row_r + ROW_W'(1);
                state_nxt = S_REPORT;
              end
            end
            tcce_pkg::OP_CR: begin
              col_nxt   = '0;
              phase_nxt = '0;
              state_nxt = S_REPORT;
            end
            default: state_nxt = S_WRITE;
          endcase
        end
      end
      S_WRITE: begin
        if (emit_ok) begin
          emit          = 1'b1;
          out_kind_nxt  = tcce_pkg::KIND_WRITE;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_glyph_nxt = (cmd_r.op == tcce_pkg::OP_TAB) ? tcce_pkg::GLYPH_SPACE : cmd_r.glyph;
          out_fore_nxt  = fore_sel;
          out_back_nxt  = back_sel;
          out_last_nxt  = 1'b0;
          state_nxt     = S_REPORT;
          if (cmd_r.op == tcce_pkg::OP_TAB || cmd_r.adv) begin
            if (col_inc >= COL_W'(COLUMNS)) begin
              // line end: wrap with a newline, which also ends any tab
              col_nxt   = '0;
              phase_nxt = '0;
              if (row_at_bottom) begin
                state_nxt = S_SCROLL;
              end else begin
                row_nxt = row_r + ROW_W'(1);
              end
            end else begin
              col_nxt = col_inc;
              if (phase_inc == (PHASE_W + 1)'(TAB_STOP)) begin
                phase_nxt = '0;
              end else begin
                phase_nxt = phase_inc[PHASE_W-1:0];
                if (cmd_r.op == tcce_pkg::OP_TAB) begin
                  state_nxt = S_WRITE;
                end
              end
            end
          end
        end
      end
      S_SCROLL: begin
        if (emit_ok) begin
          emit          = 1'b1;
          out_kind_nxt  = tcce_pkg::KIND_SCROLL;
          out_col_nxt   = '0;
          out_row_nxt   = ROW_W'(ROWS - 1);
          out_glyph_nxt = '0;
          out_fore_nxt  = '0;
          out_back_nxt  = back_color_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_REPORT;
        end
      end
      S_REPORT: begin
        if (emit_ok) begin
          emit          = 1'b1;
          out_kind_nxt  = tcce_pkg::KIND_REPORT;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_glyph_nxt = '0;
          out_fore_nxt  = '0;
          out_back_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
      text_color_r <= tcce_pkg::TEXT_COLOR_RST;
      back_color_r <= tcce_pkg::BACK_COLOR_RST;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tcce_pkg::REG_TEXT_COLOR: text_color_r <= cfg_data;
          tcce_pkg::REG_BACK_COLOR: back_color_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    out_kind_r  <= out_kind_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_fore_r  <= out_fore_nxt;
    out_back_r  <= out_back_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.cell_column = out_col_r;
  assign out_chan.cell_row    = out_row_r;
  assign out_chan.glyph       = out_glyph_r;
  assign out_chan.fore_color  = out_fore_r;
  assign out_chan.back_fill   = out_back_r;
  assign out_chan.last        = out_last_r;

  `TCCE_CHECK(a_col_range, clk, rst_n, col_r < COL_W'(COLUMNS), "cursor column off the grid")
  `TCCE_CHECK(a_row_range, clk, rst_n, row_r < ROW_W'(ROWS), "cursor row off the grid")
  `TCCE_CHECK(a_phase_home, clk, rst_n, (col_r != '0) || (phase_r == '0), "tab phase out of step")
  `TCCE_CHECK_NEXT(a_report_ends, clk, rst_n, (state_r == S_REPORT) && emit_ok, state_r == S_IDLE && out_last_r, "report did not close the item")

endmodule

/* src/text_console_cursor_engine.sv */
// a character is classified by the front end, held in the command queue and popped by the back end as a command
// then one result word per cycle while the output channel is ready, each item ending with a report word
// with the queue empty, the first result word passes the queue, the back-end command register and the output register
// the command queue accepts characters while the back end is busy, up to its depth
// synchronous active-low reset: cursor at column 0 row 0, text color 7, back color 0
module text_console_cursor_engine #(
  parameter int COLUMNS     = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP    = tcce_pkg::TAB_STOP_DEF,
  parameter int QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  tcce_in_if.sink                         in_chan,
  tcce_out_if.source                      out_chan
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  tcce_pkg::cmd_t push_data, pop_data;

  tcce_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcce_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule
